>>> hdl/dttf_pkg.sv
package dttf_pkg;

   // longest string tracked; the stop position saturates below this
   localparam int MAX_STRING_LENGTH = 1024;
   localparam logic [9:0] POS_LIMIT =
      10'((MAX_STRING_LENGTH - 1) < 1023 ? (MAX_STRING_LENGTH - 1) : 1023);

   // integer part saturation, Q15 magnitude
   localparam logic [14:0] INT_LIMIT = 15'd32767;

   // character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      PHASE_START,
      PHASE_INT,
      PHASE_FRAC,
      PHASE_SKIP
   } phase_type;

   // parser state as seen by the result formatter
   typedef struct packed {
      logic        negative;
      logic [14:0] integer_part;
      logic [15:0] fraction;
      logic [9:0]  position;
      logic        digit_seen;
   } snap_type;

endpackage

>>> hdl/dttf_parse.sv
module dttf_parse #(
   parameter int FRACTION_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        char_byte,
   output logic              emit,
   output dttf_pkg::snap_type snap
);
   import dttf_pkg::*;

   localparam int WEIGHT_COUNT = 16;
   localparam int WIDX_W = $clog2(WEIGHT_COUNT);

   typedef logic [WEIGHT_COUNT-1:0][FRACTION_BITS-1:0] weight_table_type;

   // digit weights: one tenth, then (w + 5) / 10 per digit
   function automatic weight_table_type build_weights();
      logic [32:0]      w;
      weight_table_type t;
      w = ((33'd1 << FRACTION_BITS) + 33'd5) / 33'd10;
      for (int i = 0; i < WEIGHT_COUNT; i++) begin
         t[i] = w[FRACTION_BITS-1:0];
         w = (w + 33'd5) / 33'd10;
      end
      return t;
   endfunction

   localparam weight_table_type WEIGHT_TABLE = build_weights();

   phase_type                phase_ff, phase_in;
   logic                     neg_ff, neg_in;
   logic [14:0]              int_ff, int_in;
   logic [FRACTION_BITS-1:0] frac_ff, frac_in;
   logic [WIDX_W-1:0]        widx_ff, widx_in;
   logic [9:0]               pos_ff, pos_in;
   logic                     seen_ff, seen_in;

   logic                     is_digit, is_point, is_sign, is_nul;
   logic [3:0]               digit;
   logic                     int_path;
   logic                     take_space, take_sign, take_int_digit, take_point;
   logic                     take_frac_digit, skip_end, do_emit, restart, advance;
   logic [18:0]              int_ext, int_sum;
   logic [FRACTION_BITS-1:0] weight;
   logic [FRACTION_BITS+3:0] frac_sum;
   logic [FRACTION_BITS+15:0] frac_wide;

   // character classes
   assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
   assign digit    = is_digit ? 4'(char_byte - CHAR_ZERO) : 4'd0;
   assign is_point = (char_byte == CHAR_POINT) || (char_byte == CHAR_COMMA);
   assign is_sign  = (char_byte == CHAR_PLUS) || (char_byte == CHAR_MINUS);
   assign is_nul   = (char_byte == CHAR_NUL);

   // decode what this character does in the current phase
   always_comb begin
      int_path        = 1'b0;
      take_space      = 1'b0;
      take_sign       = 1'b0;
      take_int_digit  = 1'b0;
      take_point      = 1'b0;
      take_frac_digit = 1'b0;
      skip_end        = 1'b0;
      do_emit         = 1'b0;
      unique case (phase_ff)
         PHASE_START: begin
            if (char_byte == CHAR_SPACE) begin
               take_space = 1'b1;
            end else if (is_sign) begin
               take_sign = 1'b1;
            end else begin
               int_path = 1'b1;
            end
         end
         PHASE_INT: begin
            int_path = 1'b1;
         end
         PHASE_FRAC: begin
            if (is_digit) begin
               take_frac_digit = 1'b1;
            end else begin
               do_emit = 1'b1;
            end
         end
         PHASE_SKIP: begin
            skip_end = is_nul;
         end
         default: begin
            skip_end = 1'b0;
         end
      endcase
      // start phase falls through to integer handling
      if (int_path) begin
         priority if (is_digit) begin
            take_int_digit = 1'b1;
         end else if (is_point) begin
            take_point = 1'b1;
         end else begin
            do_emit = 1'b1;
         end
      end
   end

   assign restart = skip_end || (do_emit && is_nul);
   assign advance = take_space || take_sign || take_int_digit || take_point
                    || take_frac_digit;
   assign emit    = fire && do_emit;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         priority if (restart) begin
            phase_in = PHASE_START;
         end else if (do_emit) begin
            phase_in = PHASE_SKIP;
         end else if (take_point) begin
            phase_in = PHASE_FRAC;
         end else if (take_sign || take_int_digit) begin
            phase_in = PHASE_INT;
         end else begin
            phase_in = phase_ff;
         end
      end
   end

   // integer accumulate: x*10 + d, saturating
   assign int_ext = {4'd0, int_ff};
   assign int_sum = (int_ext << 3) + (int_ext << 1) + {15'd0, digit};

   // fraction accumulate: acc + d*weight, saturating
   assign weight   = WEIGHT_TABLE[widx_ff];
   assign frac_sum = {4'd0, frac_ff} + ({{FRACTION_BITS{1'b0}}, digit} * {4'd0, weight});

   // datapath next values
   always_comb begin
      neg_in  = neg_ff;
      int_in  = int_ff;
      frac_in = frac_ff;
      widx_in = widx_ff;
      pos_in  = pos_ff;
      seen_in = seen_ff;
      if (restart) begin
         neg_in  = 1'b0;
         int_in  = '0;
         frac_in = '0;
         widx_in = '0;
         pos_in  = '0;
         seen_in = 1'b0;
      end else begin
         if (advance && (pos_ff < POS_LIMIT)) begin
            pos_in = pos_ff + 10'd1;
         end
         if (take_sign) begin
            neg_in = (char_byte == CHAR_MINUS);
         end
         if (take_int_digit) begin
            int_in  = (int_sum > {4'd0, INT_LIMIT}) ? INT_LIMIT : int_sum[14:0];
            seen_in = 1'b1;
         end
         if (take_frac_digit) begin
            frac_in = (frac_sum[FRACTION_BITS+3:FRACTION_BITS] != 4'd0) ?
                      '1 : frac_sum[FRACTION_BITS-1:0];
            seen_in = 1'b1;
            // the table ends in a zero weight, which then holds
            if (widx_ff != WIDX_W'(WEIGHT_COUNT - 1)) begin
               widx_in = widx_ff + WIDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_START;
         neg_ff   <= 1'b0;
         int_ff   <= '0;
         frac_ff  <= '0;
         widx_ff  <= '0;
         pos_ff   <= '0;
         seen_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (fire) begin
            neg_ff  <= neg_in;
            int_ff  <= int_in;
            frac_ff <= frac_in;
            widx_ff <= widx_in;
            pos_ff  <= pos_in;
            seen_ff <= seen_in;
         end
      end
   end

   // fraction truncated to Q0.16
   assign frac_wide = {frac_ff, 16'd0};

   always_comb begin
      snap.negative     = neg_ff;
      snap.integer_part = int_ff;
      snap.fraction     = frac_wide[FRACTION_BITS+15:FRACTION_BITS];
      snap.position     = pos_ff;
      snap.digit_seen   = seen_ff;
   end

   a_no_emit_in_skip: assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_ff != PHASE_SKIP))
      else $error("result emitted while skipping to end of string");

   a_skip_after_stop: assert property (@(posedge clock) disable iff (reset)
      (emit && !is_nul) |=> (phase_ff == PHASE_SKIP))
      else $error("stop before terminator did not enter skip phase");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && restart) |=> (int_ff == '0) && (frac_ff == '0) && !seen_ff
                            && (pos_ff == '0) && (phase_ff == PHASE_START))
      else $error("new string did not start from cleared state");

   a_no_digit_zero: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (int_ff == '0) && (frac_ff == '0))
      else $error("accumulators nonzero without any digit");

   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LIMIT)
      else $error("character position beyond limit");

endmodule

>>> hdl/dttf_format.sv
module dttf_format (
   input  dttf_pkg::snap_type  snap,
   output logic signed [31:0]  parsed_value,
   output logic [9:0]          stop_position,
   output logic                not_a_number
);
   import dttf_pkg::*;

   logic [31:0] mag;

   // Q15.16 magnitude, then sign; a negative zero stays zero
   assign mag           = {1'b0, snap.integer_part, snap.fraction};
   assign parsed_value  = snap.negative ? -$signed(mag) : $signed(mag);
   assign stop_position = snap.position;
   assign not_a_number  = !snap.digit_seen;

endmodule

>>> hdl/decimal_text_to_fixed_point.sv
// A character accepted at a clock edge waits in the input register; its result, if any,
// is then captured by the result register and shown on rsp_valid.
// Throughput: one character per cycle unless back-pressure stalls; the parse state updates once per character.
// Back-pressure on rsp_ready stalls the input register, then req_ready.
// Reset (synchronous, active high) clears the handshake registers and returns the
// parser to the start of a new string.
module decimal_text_to_fixed_point #(
   parameter int FRACTION_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_parsed_value,
   output logic [9:0]         rsp_stop_position,
   output logic               rsp_not_a_number
);
   import dttf_pkg::*;

   logic              in_valid_ff;
   logic [7:0]        in_char_ff;
   logic              out_valid_ff, out_valid_in;
   logic signed [31:0] value_ff;
   logic [9:0]        pos_ff;
   logic              nan_ff;

   logic              step;
   logic              emit;
   snap_type          snap;
   logic signed [31:0] value_next;
   logic [9:0]        pos_next;
   logic              nan_next;

   // the input stage moves on when the result register is free or draining
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_byte;
      end
   end

   dttf_parse #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .fire     (step),
      .char_byte(in_char_ff),
      .emit     (emit),
      .snap     (snap)
   );

   dttf_format u_format (
      .snap         (snap),
      .parsed_value (value_next),
      .stop_position(pos_next),
      .not_a_number (nan_next)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      priority if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         value_ff <= value_next;
         pos_ff   <= pos_next;
         nan_ff   <= nan_next;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_parsed_value  = value_ff;
   assign rsp_stop_position = pos_ff;
   assign rsp_not_a_number  = nan_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!out_valid_ff || rsp_ready))
      else $error("result register overwritten before transaction");

   a_step_needs_item: assert property (@(posedge clock) disable iff (reset)
      step |-> in_valid_ff)
      else $error("parser stepped without a held character");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |=> in_valid_ff)
      else $error("input character lost during stall");

endmodule
